[design/assert_macros.svh]
// Assertion helper macros shared by the RTL files.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/tdpt_pkg.sv]
// Shared types and constants for the trial division prime test.
// No dependencies.
`timescale 1ns / 1ps

package tdpt_pkg;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    // Request from the sequencer to the remainder unit
    typedef struct packed {
        logic start;
    } t_div_req;

    // Status from the remainder unit back to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_rsp;

    localparam int unsigned FIRST_DIVISOR = 3;
    localparam int unsigned FIRST_SQUARE  = 9;
    localparam int unsigned OUT_BYTES     = 1;

endpackage

[design/tdpt_divider.sv]
// Iterative restoring remainder unit: one quotient bit per cycle.
// Depends on tdpt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdpt_divider import tdpt_pkg::*; #(
    parameter int unsigned W  = 32,
    parameter int unsigned DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_req      i_req,
    input  logic [W-1:0]  i_dividend,
    input  logic [DW-1:0] i_divisor,
    output t_div_rsp      o_rsp
);

    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_quot, n_quot;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DW:0]   trial;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quot[W-1]};
        if (i_req.start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quot = {r_quot[W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = DW'(trial - {1'b0, r_dvs});
            end else begin
                n_rem = trial[DW-1:0];
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        if (i_req.start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.rem_zero = (r_rem == '0);

    `ASSERT_IMPL(a_no_start_busy, i_clk, i_rst_n, i_req.start, !r_busy, "start while busy")
    `ASSERT_IMPL(a_done_after_busy, i_clk, i_rst_n, r_done, $past(r_busy), "done without work")
    `ASSERT_IMPL(a_rem_below_dvs, i_clk, i_rst_n, r_busy, r_rem < r_dvs, "remainder too large")

endmodule

[design/trial_division_prime_test.sv]
// Top level of the trial division prime test.
// Depends on tdpt_pkg, tdpt_divider and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Tests one unsigned number per input transfer and returns one byte whose bit 0
// is 1 when the number is prime. Only the low min(VALUE_WIDTH, 32) bits of the
// input are used. 0, 1, 2 and other even numbers need no division: the state
// goes from idle to finish, and the result is written to the output register
// once that register is free, at which point the input is ready again. Odd
// numbers try odd divisors from 3 upward while divisor squared does not exceed
// the number; each trial runs the bound check, then W quotient-bit steps of the
// single bit-serial remainder unit and its registered done flag, with
// W = min(VALUE_WIDTH, 32), so a 32-bit prime near 2^32 needs roughly 32767
// trials. The input is not ready while a number is in work; a finished result
// waits in the output register and the next number can be taken meanwhile.
module trial_division_prime_test import tdpt_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [0] is_prime, [7:1] zero
);

    localparam int unsigned W   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int unsigned DW  = W / 2 + 1;
    localparam int unsigned SQW = 2 * DW;

    t_state        r_state, n_state;
    logic [W-1:0]  r_n, n_n;
    logic [DW-1:0] r_d, n_d;
    logic [SQW-1:0] r_sq, n_sq;
    logic          r_res, n_res;
    logic          r_out_valid, n_out_valid;
    logic          r_out_bit, n_out_bit;
    logic [W-1:0]  in_n;
    t_div_req      div_req;
    t_div_rsp      div_rsp;

    assign in_n = i_s_axis_tdata[W-1:0];
    assign o_s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state       = r_state;
        n_n           = r_n;
        n_d           = r_d;
        n_sq          = r_sq;
        n_res         = r_res;
        n_out_valid   = r_out_valid;
        n_out_bit     = r_out_bit;
        div_req.start = 1'b0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_n  = in_n;
                    n_d  = DW'(FIRST_DIVISOR);
                    n_sq = SQW'(FIRST_SQUARE);
                    if (in_n <= W'(1)) begin
                        n_res   = 1'b0;
                        n_state = ST_FINISH;
                    end else if (in_n == W'(2)) begin
                        n_res   = 1'b1;
                        n_state = ST_FINISH;
                    end else if (!in_n[0]) begin
                        n_res   = 1'b0;
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (r_sq > SQW'(r_n)) begin
                    n_res   = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem_zero) begin
                        n_res   = 1'b0;
                        n_state = ST_FINISH;
                    end else begin
                        // (d+2)^2 = d^2 + 4d + 4
                        n_sq    = r_sq + {{(SQW-DW-2){1'b0}}, r_d, 2'b00} + SQW'(4);
                        n_d     = r_d + DW'(2);
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_d       <= n_d;
        r_sq      <= n_sq;
        r_res     <= n_res;
        r_out_bit <= n_out_bit;
    end

    tdpt_divider #(
        .W  (W),
        .DW (DW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_rsp      (div_rsp)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(8*OUT_BYTES-1){1'b0}}, r_out_bit};

    `ASSERT_IMPL(a_done_in_div, i_clk, i_rst_n, div_rsp.done, r_state == ST_DIV, "stray done")
    `ASSERT_IMPL(a_odd_divisor, i_clk, i_rst_n, r_state == ST_CHECK, r_d[0], "even divisor")
    `ASSERT_NEXT(a_start_to_div, i_clk, i_rst_n, div_req.start, r_state == ST_DIV, "start lost")

endmodule
